// File: rtl/core/eye_aspect_ratio_check_unit_defines.svh
// Assertion macros for the eye aspect ratio blocks; ear_merge uses them.
`ifndef EYE_ASPECT_RATIO_CHECK_UNIT_DEFINES_SVH
`define EYE_ASPECT_RATIO_CHECK_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define EAR_ASSERT_IMPL(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define EAR_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ear_pkg.sv
package ear_pkg;

	localparam int unsigned EarFracBits = 12;
	localparam int unsigned EarWidth    = 16;
	localparam logic [15:0] EarMax      = 16'hFFFF;
	localparam logic [15:0] ThreshReset = 16'd819;

	// Lane identifiers for the three distances.
	typedef enum logic [1:0] {
		LANE_D26 = 2'd0,
		LANE_D35 = 2'd1,
		LANE_D14 = 2'd2
	} lane_id_t;

endpackage

// File: rtl/core/ear_dist_lane.sv
// One distance lane: |a-b| per axis, squares, sum, then a pipelined
// restoring square root, one result bit per stage.
module ear_dist_lane #(
	parameter int unsigned CW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [CW-1:0]   ax,
	input  logic [CW-1:0]   ay,
	input  logic [CW-1:0]   bx,
	input  logic [CW-1:0]   by,
	output logic            out_valid,
	output logic [CW:0]     span
);
	localparam int unsigned SW = 2*CW + 2;   // sum width, even
	localparam int unsigned NB = SW / 2;     // root bits

	logic [CW-1:0] dx_s1, dy_s1;
	logic          v_s1;
	logic [2*CW-1:0] sx_s2, sy_s2;
	logic          v_s2;
	logic          v_s3;

	// Entry 0 is the square sum register (third front stage).
	logic [SW-1:0] rad_q  [NB+1];
	logic [NB+1:0] rem_q  [NB+1];
	logic [NB-1:0] root_q [NB+1];
	logic [NB-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1     <= (ax >= bx) ? ax - bx : bx - ax;
		dy_s1     <= (ay >= by) ? ay - by : by - ay;
		sx_s2     <= dx_s1 * dx_s1;
		sy_s2     <= dy_s1 * dy_s1;
		rad_q[0]  <= {2'b00, sx_s2} + {2'b00, sy_s2};
		rem_q[0]  <= '0;
		root_q[0] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[NB-2:0], v_s3};
	end

	// Drop into one stage per root bit.
	for (genvar i = 0; i < NB; i++) begin : g_sq
		logic [NB+1:0] rem_n, trial;
		always_comb begin
			rem_n = {rem_q[i][NB-1:0], rad_q[i][SW-1 -: 2]};
			trial = {root_q[i], 2'b01};
		end
		always_ff @(posedge clk) begin
			rad_q[i+1] <= rad_q[i] << 2;
			if (rem_n >= trial) begin
				rem_q[i+1]  <= rem_n - trial;
				root_q[i+1] <= {root_q[i][NB-2:0], 1'b1};
			end else begin
				rem_q[i+1]  <= rem_n;
				root_q[i+1] <= {root_q[i][NB-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_q[NB-1];
	assign span      = root_q[NB][CW:0];
endmodule

// File: rtl/core/ear_merge.sv
`include "eye_aspect_ratio_check_unit_defines.svh"
// Merge: sum of lid distances over twice the corner distance, by a
// pipelined restoring divider (one quotient bit per stage), then saturate
// and compare with the threshold. The operands are registered first.
module ear_merge #(
	parameter int unsigned CW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [CW:0]   d26,
	input  logic [CW:0]   d35,
	input  logic [CW:0]   d14,
	input  logic [15:0]   threshold,
	output logic          out_valid,
	output logic [15:0]   ratio,
	output logic          closed,
	output logic          degen
);
	localparam int unsigned QW = 17;               // enough to see saturation
	localparam int unsigned NW = CW + 2 + ear_pkg::EarFracBits; // numerator
	localparam int unsigned DW = CW + 2;           // divisor 2*d14

	logic [NW-1:0] num_0;
	logic [DW-1:0] den_0;
	logic [NW-1:0] num_q [QW+1];
	logic [DW-1:0] den_q [QW+1];
	logic [QW-1:0] quo_q [QW+1];
	logic          dg_q  [QW+1];
	logic          ov_q  [QW+1];
	logic          ovf_big_q [QW+1];
	logic [QW:0]   vld_q;

	always_comb begin
		num_0 = {({1'b0, d26} + {1'b0, d35}), {ear_pkg::EarFracBits{1'b0}}};
		den_0 = {d14, 1'b0};
	end

	// Quotient may exceed QW bits only if num >= den<<QW; flag it up front.
	always_ff @(posedge clk) begin
		num_q[0]     <= num_0;
		den_q[0]     <= den_0;
		quo_q[0]     <= '0;
		dg_q[0]      <= (d14 == '0);
		ov_q[0]      <= 1'b0;
		ovf_big_q[0] <= ({{(QW+1){1'b0}}, num_0} >= ({{NW{1'b0}}, den_0} << QW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[QW-1:0], in_valid};
	end

	// Bits above quotient position QW-1 only set an overflow flag.
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int unsigned SH = QW - 1 - i;
		logic [NW+QW:0] part;
		logic [NW+QW:0] dsh;
		logic           ge;
		always_comb begin
			part = {{(QW+1){1'b0}}, num_q[i]};
			dsh  = {{(NW+QW+1-DW){1'b0}}, den_q[i]} << SH;
			ge   = (i == 0) ? (part >= dsh) : 1'b0;
		end
		always_ff @(posedge clk) begin
			den_q[i+1] <= den_q[i];
			dg_q[i+1]  <= dg_q[i];
			// Restoring step on the running remainder held in num.
			if (part >= dsh && den_q[i] != '0) begin
				num_q[i+1]  <= num_q[i] - dsh[NW-1:0];
				quo_q[i+1]  <= quo_q[i] | (QW'(1) << SH);
				ov_q[i+1]   <= ov_q[i] | (ge & ~dsh[NW+QW]);
			end else begin
				num_q[i+1]  <= num_q[i];
				quo_q[i+1]  <= quo_q[i];
				ov_q[i+1]   <= ov_q[i];
			end
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_ov
		always_ff @(posedge clk) ovf_big_q[j+1] <= ovf_big_q[j];
	end

	logic [QW-1:0] qf;
	logic          sat;
	always_comb begin
		qf  = quo_q[QW];
		sat = dg_q[QW] || ovf_big_q[QW] || ov_q[QW] || (qf[QW-1:16] != '0);
		ratio  = sat ? ear_pkg::EarMax : qf[15:0];
		closed = !dg_q[QW] && (ratio < threshold);
		degen  = dg_q[QW];
	end
	assign out_valid = vld_q[QW];

	`EAR_ASSERT_IMPL(a_degen_open, clk, arst_n, out_valid && degen, !closed, "degenerate closed")
	`EAR_ASSERT_IMPL(a_degen_max, clk, arst_n, out_valid && degen, ratio == ear_pkg::EarMax, "degenerate ratio")
	`EAR_ASSERT_NEXT(a_flow, clk, arst_n, vld_q[QW-1], out_valid, "valid lost in divider")
endmodule

// File: rtl/core/eye_aspect_ratio_check_unit.sv
// Eye aspect ratio check. Pulse start with the six landmark points of one
// eye; busy is never raised, so an item may be issued on every clock. Three
// distance lanes (p2-p6, p3-p5, p1-p4) run side by side, each a subtract,
// square and add front end followed by a square root that retires one bit
// per stage; a divider that registers its operands and retires one quotient
// bit per stage then forms EAR. Throughput is one item per cycle. Each
// result appears for exactly one cycle with done high and cannot be held
// off: capture it on that edge. Write the threshold (cfg_we, cfg_wdata)
// only while no item is in flight.
module eye_aspect_ratio_check_unit #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
	input  logic [COORD_WIDTH-1:0] p4_x, p4_y, p5_x, p5_y, p6_x, p6_y,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	output logic                   done,
	output logic [15:0]            aspect_ratio,
	output logic                   eye_closed,
	output logic                   degenerate
);
	logic [15:0] thresh_q;
	logic        acc;
	logic [2:0]  lv;
	logic [COORD_WIDTH:0] d26, d35, d14;
	logic        mv;
	logic [15:0] mr;
	logic        mc, md;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// Hold the threshold; reset to 0.2 in 4.12.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thresh_q <= ear_pkg::ThreshReset;
		else if (cfg_we) thresh_q <= cfg_wdata;
	end

	ear_dist_lane #(.CW(COORD_WIDTH)) u_l26 (.clk, .arst_n, .in_valid(acc),
		.ax(p2_x), .ay(p2_y), .bx(p6_x), .by(p6_y), .out_valid(lv[0]), .span(d26));
	ear_dist_lane #(.CW(COORD_WIDTH)) u_l35 (.clk, .arst_n, .in_valid(acc),
		.ax(p3_x), .ay(p3_y), .bx(p5_x), .by(p5_y), .out_valid(lv[1]), .span(d35));
	ear_dist_lane #(.CW(COORD_WIDTH)) u_l14 (.clk, .arst_n, .in_valid(acc),
		.ax(p1_x), .ay(p1_y), .bx(p4_x), .by(p4_y), .out_valid(lv[2]), .span(d14));

	// The lanes run in lockstep; advance the merge when all three agree.
	ear_merge #(.CW(COORD_WIDTH)) u_merge (.clk, .arst_n, .in_valid(&lv),
		.d26, .d35, .d14, .threshold(thresh_q),
		.out_valid(mv), .ratio(mr), .closed(mc), .degen(md));

	// Register the result for one clean strobe cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= mv;
	end
	always_ff @(posedge clk) begin
		aspect_ratio <= mr;
		eye_closed   <= mc;
		degenerate   <= md;
	end
endmodule

// File: sim/ear_result_checker.sv
`timescale 1ns / 100ps

module ear_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
	input  logic [15:0] p4_x, p4_y, p5_x, p5_y, p6_x, p6_y,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        done,
	input  logic [15:0] aspect_ratio,
	input  logic        eye_closed,
	input  logic        degenerate,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [15:0] ratio;
		logic        closed;
		logic        degen;
	} ear_result_t;

	ear_result_t expected_q[$];
	logic [15:0] threshold;

	function automatic logic [32:0] int_sqrt(logic [32:0] v);
		logic [33:0] root;
		logic [33:0] rem;
		logic [33:0] trial;
		root = '0;
		rem  = '0;
		for (int i = 16; i >= 0; i--) begin
			rem   = (rem << 2) | ((v >> (2 * i)) & 33'd3);
			trial = (root << 2) | 34'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 34'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[32:0];
	endfunction

	function automatic logic [32:0] point_dist(logic [15:0] ax, ay, bx, by);
		logic [15:0] dx;
		logic [15:0] dy;
		dx = (ax >= bx) ? ax - bx : bx - ax;
		dy = (ay >= by) ? ay - by : by - ay;
		return int_sqrt(33'(32'(dx) * 32'(dx)) + 33'(32'(dy) * 32'(dy)));
	endfunction

	function automatic ear_result_t predict_ear();
		logic [32:0] d26, d35, d14;
		logic [63:0] ratio;
		ear_result_t r;
		d26 = point_dist(p2_x, p2_y, p6_x, p6_y);
		d35 = point_dist(p3_x, p3_y, p5_x, p5_y);
		d14 = point_dist(p1_x, p1_y, p4_x, p4_y);
		if (d14 == 0) begin
			r.ratio  = 16'hFFFF;
			r.closed = 1'b0;
			r.degen  = 1'b1;
		end else begin
			ratio = ((64'(d26) + 64'(d35)) << 12) / (64'(d14) << 1);
			if (ratio > 64'hFFFF)
				ratio = 64'hFFFF;
			r.ratio  = ratio[15:0];
			r.closed = (ratio[15:0] < threshold);
			r.degen  = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ear_result_t e;
		int errs;
		if (!arst_n) begin
			threshold  <= 16'd819;
			fail_count <= 0;
			pending    <= 0;
			expected_q.delete();
		end else begin
			errs = 0;
			if (cfg_we)
				threshold <= cfg_wdata;
			if (start && !busy)
				expected_q.insert(expected_q.size(), predict_ear());
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no item outstanding");
					errs = errs + 1;
				end else begin
					e = expected_q.pop_front();
					if (aspect_ratio !== e.ratio) begin
						$error("aspect_ratio expected %0d actual %0d", e.ratio, aspect_ratio);
						errs = errs + 1;
					end
					if (eye_closed !== e.closed) begin
						$error("eye_closed expected %0d actual %0d", e.closed, eye_closed);
						errs = errs + 1;
					end
					if (degenerate !== e.degen) begin
						$error("degenerate expected %0d actual %0d", e.degen, degenerate);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= expected_q.size();
		end
	end

endmodule

// File: sim/tb_eye_aspect_ratio_check_unit.sv
`timescale 1ns / 100ps

module tb_eye_aspect_ratio_check_unit;

	localparam int Latency = 3 + 17 + 18 + 1;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] pt [12];
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        done;
	logic [15:0] aspect_ratio;
	logic        eye_closed;
	logic        degenerate;
	int          fail_count;
	int          pending;
	int          idle_pct;

	eye_aspect_ratio_check_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p1_x(pt[0]), .p1_y(pt[1]), .p2_x(pt[2]), .p2_y(pt[3]),
		.p3_x(pt[4]), .p3_y(pt[5]), .p4_x(pt[6]), .p4_y(pt[7]),
		.p5_x(pt[8]), .p5_y(pt[9]), .p6_x(pt[10]), .p6_y(pt[11]),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.aspect_ratio(aspect_ratio), .eye_closed(eye_closed), .degenerate(degenerate)
	);

	ear_result_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p1_x(pt[0]), .p1_y(pt[1]), .p2_x(pt[2]), .p2_y(pt[3]),
		.p3_x(pt[4]), .p3_y(pt[5]), .p4_x(pt[6]), .p4_y(pt[7]),
		.p5_x(pt[8]), .p5_y(pt[9]), .p6_x(pt[10]), .p6_y(pt[11]),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.aspect_ratio(aspect_ratio), .eye_closed(eye_closed), .degenerate(degenerate),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#4ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Present one eye and hold it until accepted; idle first at the phase rate.
	task automatic send_eye(logic [15:0] p [12]);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		for (int i = 0; i < 12; i++)
			pt[i] <= p[i];
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start, let the pipeline drain, then write the threshold.
	task automatic set_threshold(logic [15:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a well-formed eye around a random center, else random points.
	task automatic random_eye(output logic [15:0] p [12]);
		int cx, cy, w, h;
		case ($urandom_range(9))
			0: for (int i = 0; i < 12; i++) p[i] = 16'($urandom);
			1: begin
				for (int i = 0; i < 12; i++) p[i] = 16'($urandom);
				p[6] = p[0];
				p[7] = p[1];
			end
			default: begin
				w  = $urandom_range(1, 4000);
				h  = $urandom_range(0, w);
				cx = $urandom_range(w, 65535 - w);
				cy = $urandom_range(h, 65535 - h);
				p[0]  = 16'(cx - w);
				p[1]  = 16'(cy + $urandom_range(0, 40) - 20);
				p[6]  = 16'(cx + w - $urandom_range(0, w));
				p[7]  = 16'(cy);
				p[2]  = 16'(cx - w / 3);
				p[3]  = 16'(cy - $urandom_range(0, h));
				p[4]  = 16'(cx + w / 3);
				p[5]  = 16'(cy - $urandom_range(0, h));
				p[8]  = 16'(cx + w / 3 + $urandom_range(0, 30));
				p[9]  = 16'(cy + $urandom_range(0, h));
				p[10] = 16'(cx - w / 3);
				p[11] = 16'(cy + $urandom_range(0, h));
			end
		endcase
	endtask

	initial begin
		logic [15:0] p [12];
		logic [15:0] thr [4];
		int phase_pct [4];
		thr       = '{16'd0, 16'hFFFF, 16'd819, 16'd2000};
		phase_pct = '{0, 74, 0, 7};
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		idle_pct  = 0;
		for (int i = 0; i < 12; i++)
			pt[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all zero (degenerate with zero numerator), all max, corners.
		for (int i = 0; i < 12; i++) p[i] = 16'h0000;
		send_eye(p);
		for (int i = 0; i < 12; i++) p[i] = 16'hFFFF;
		send_eye(p);
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
			16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
		send_eye(p);   // tiny corner distance, huge lids: saturates
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
		send_eye(p);   // zero numerator, largest corner distance
		p = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
		send_eye(p);   // all diagonals at full extent
		p = '{16'd100, 16'd200, 16'd140, 16'd180, 16'd180, 16'd180,
			16'd220, 16'd200, 16'd180, 16'd220, 16'd140, 16'd220};
		send_eye(p);   // ordinary open eye
		p = '{16'd100, 16'd200, 16'd140, 16'd198, 16'd180, 16'd198,
			16'd220, 16'd200, 16'd180, 16'd202, 16'd140, 16'd202};
		send_eye(p);   // nearly shut eye

		// Random phases across threshold settings and idle rates.
		for (int ph = 0; ph < 4; ph++) begin
			set_threshold(thr[ph]);
			idle_pct = phase_pct[ph];
			for (int n = 0; n < 385; n++) begin
				random_eye(p);
				send_eye(p);
			end
		end
		start <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (Latency) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
